// ===== rtl/rsw_pkg.sv =====
// Package for the send window engine: command and register codes,
// Q7.8 window constants and the divider status type. No dependencies.
`timescale 1ns / 1ps
package rsw_pkg;

  // Input commands.
  localparam logic [2:0] CMD_START    = 3'd0;
  localparam logic [2:0] CMD_ACK_HDR  = 3'd1;
  localparam logic [2:0] CMD_SACK     = 3'd2;
  localparam logic [2:0] CMD_ACK_DONE = 3'd3;
  localparam logic [2:0] CMD_TICK     = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_SEGMENT_COUNT = 2'd0;
  localparam logic [1:0] REG_TIMEOUT       = 2'd1;
  localparam logic [1:0] REG_PEER_WINDOW   = 2'd2;

  // Window constants in unsigned Q7.8.
  localparam logic [14:0] Q_ONE   = 15'd256;
  localparam logic [14:0] Q_CAP   = 15'd16384;
  localparam logic [14:0] Q_FLOOR = 15'd512;
  localparam logic [14:0] Q_THREE = 15'd768;
  localparam logic [14:0] Q_START = 15'd4096;

  localparam logic [7:0] DUP_TRIGGER = 8'd3;
  localparam logic [7:0] DUP_MAX     = 8'd255;
  localparam logic [5:0] MAX_SENDS   = 6'd63;

  // Status of the reciprocal divider.
  typedef struct packed {
    logic busy;
    logic done;
  } rsw_div_stat_t;

endpackage

// ===== rtl/reno_sack_send_window_core.sv =====
// Top level of the Reno send window engine with selective acknowledgement.
// Depends on rsw_pkg, rsw_ram (slot ring) and rsw_div (reciprocal).
//
//  channel | direction | contents
//  in_     | slave     | command items: start, ack header, sack, ack done, tick
//  out_    | master    | transmissions, then one status transfer with tlast
//  cfg_    | slave     | register writes: index and data, always ready
//
// Each item is decoded, then every ring slot it reads is read, then checked and
// written back through the single RAM port pair, up to 64 slots; each new
// segment sent is one output transfer, and an ack done that raises the window
// in avoidance waits for the serial divider to finish its quotient. Results leave
// through an output register, so a stalled output holds the engine only when
// a further result is due.
// Reset is synchronous; the ring needs no clearing since only written
// in-flight slots are ever read.
`timescale 1ns / 1ps
module reno_sack_send_window_core #(
  parameter int RING_SLOTS = 64,
  parameter int SACK_LIMIT = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  // tdata: ack_number[31:0], advertised_window[47:32], sack_start[79:48],
  //        sack_end[111:80]
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,
  // tuser: command[2:0], ack_flag[3]
  input  logic [3:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: send_segment[19:0], window_now[34:20], oldest_unacked[54:35],
  //        all_done[55]
  output logic [55:0]  out_tdata,
  // tuser: send_valid[0], is_retransmit[1]
  output logic [1:0]   out_tuser,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [19:0]  cfg_data
);
  import rsw_pkg::*;

  localparam int SW = $clog2(RING_SLOTS);
  localparam logic [SW-1:0] SLOT_LAST = SW'(RING_SLOTS - 1);
  localparam logic [SW:0] SLOT_COUNT = (SW + 1)'(RING_SLOTS);
  localparam logic [3:0] SACK_MAX = 4'(SACK_LIMIT);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_MARK_START, S_MARK_RD, S_MARK_WR, S_DUP_CHK,
    S_WALK_RD, S_WALK_CHK, S_CWND, S_DIV, S_FILL_INIT, S_FILL,
    S_TICK_RD, S_TICK_CHK, S_STATUS
  } state_t;

  state_t state_r;

  // Registers.
  logic [19:0] segcnt_r;
  logic [15:0] tmo_r;
  logic [15:0] init_peer_r;

  // Transfer state.
  logic [14:0] cong_r;
  logic [14:0] ssl_r;
  logic [15:0] peer_r;
  logic [31:0] last_ack_r;
  logic [7:0]  dup_r;
  logic        rec_r;
  logic [19:0] rp_r;
  logic [19:0] base_r;
  logic [19:0] next_r;
  logic        new_ack_r;
  logic [3:0]  taken_r;
  logic [31:0] tick_r;
  logic [SW-1:0] base_slot_r;
  logic [SW-1:0] next_slot_r;

  // Item and walk registers.
  logic [2:0]  cmd_r;
  logic        ackf_r;
  logic [31:0] ack_r;
  logic [15:0] adv_r;
  logic [31:0] sst_r;
  logic [31:0] sen_r;
  logic [5:0]  n_r;
  logic [19:0] mark_i_r;
  logic [19:0] mark_hi_r;
  logic        mark_ok_r;
  logic [SW-1:0] mark_slot_r;
  logic [19:0] limit_r;

  // Output register.
  logic        out_valid_r;
  logic        out_send_r;
  logic [19:0] out_seg_r;
  logic        out_retx_r;
  logic        out_last_r;
  logic [14:0] out_win_r;
  logic [19:0] out_old_r;
  logic        out_done_r;

  // Ring memory: {acked, send tick}.
  logic          mem_wr_en;
  logic [SW-1:0] mem_wr_addr;
  logic [32:0]   mem_wr_data;
  logic          mem_rd_en;
  logic [SW-1:0] mem_rd_addr;
  logic [32:0]   mem_rd_data;

  rsw_ram #(.WIDTH(33), .DEPTH(RING_SLOTS)) u_ring (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  rsw_div_stat_t div_stat;
  logic          div_start;
  logic [16:0]   div_q;

  rsw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (cong_r),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // Helper values.
  logic        can_put;
  logic        out_load;
  logic [14:0] half;
  logic [14:0] cut_val;
  logic [15:0] cong_inc;
  logic [14:0] cong_inc_cap;
  logic [15:0] dup_cong;
  logic [17:0] div_sum;
  logic        fill_go;
  logic        tick_exp;
  logic        ack_ok;
  logic [7:0]  dup_new;
  logic [31:0] st1;
  logic [31:0] sk_lo;
  logic [31:0] sk_hi;
  logic [31:0] hd_hi;
  logic [19:0] mark_lo;
  logic [19:0] mark_off;
  logic [SW:0] slot_sum;
  logic [SW-1:0] lo_slot;
  logic [19:0] lim_a;
  logic [19:0] lim_b;
  logic [19:0] seg_left;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    slot_inc = (s == SLOT_LAST) ? '0 : SW'(s + 1'b1);
  endfunction

  assign can_put      = !out_valid_r || out_tready;
  assign half         = {1'b0, cong_r[14:1]};
  assign cut_val      = (half < Q_FLOOR) ? Q_FLOOR : half;
  assign cong_inc     = {1'b0, cong_r} + {1'b0, Q_ONE};
  assign cong_inc_cap = (cong_inc > {1'b0, Q_CAP}) ? Q_CAP : cong_inc[14:0];
  assign dup_cong     = {1'b0, cut_val} + {1'b0, Q_THREE};
  assign div_sum      = {3'b0, cong_r} + {1'b0, div_q};
  assign fill_go      = (n_r < MAX_SENDS) && (next_r < segcnt_r) &&
                        (20'(next_r - base_r) < limit_r);
  assign tick_exp     = !mem_rd_data[32] &&
                        (32'(tick_r - mem_rd_data[31:0]) > {16'b0, tmo_r});
  assign ack_ok       = (ack_r != 32'd0) && (ack_r <= {12'b0, next_r});
  assign dup_new      = (dup_r == DUP_MAX) ? DUP_MAX : 8'(dup_r + 8'd1);
  assign div_start    = (state_r == S_CWND) && !(cong_r < ssl_r);

  // The output register takes a new transfer in this cycle.
  assign out_load = can_put &&
                    (((state_r == S_DUP_CHK) && !mem_rd_data[32]) ||
                     ((state_r == S_TICK_CHK) && tick_exp) ||
                     ((state_r == S_FILL) && fill_go) ||
                     (state_r == S_STATUS));

  // Sack range, clipped to in-flight segments.
  assign st1   = (sst_r == 32'd0) ? 32'd1 : sst_r;
  assign sk_lo = (32'(st1 - 32'd1) < {12'b0, base_r}) ? {12'b0, base_r}
                                                      : 32'(st1 - 32'd1);
  assign sk_hi = (32'(sen_r - 32'd1) > {12'b0, 20'(next_r - 20'd1)})
                 ? {12'b0, 20'(next_r - 20'd1)} : 32'(sen_r - 32'd1);
  assign hd_hi = 32'(ack_r - 32'd1);

  // Ring slot of the first marked segment, relative to the base slot.
  assign mark_lo  = (cmd_r == CMD_SACK) ? sk_lo[19:0] : base_r;
  assign mark_off = 20'(mark_lo - base_r);
  assign slot_sum = {1'b0, base_slot_r} + {1'b0, mark_off[SW-1:0]};
  assign lo_slot  = (slot_sum >= SLOT_COUNT) ? SW'(slot_sum - SLOT_COUNT)
                                             : slot_sum[SW-1:0];

  // Fill limit: min(floor(cwnd), peer window, segments left).
  assign seg_left = 20'(segcnt_r - base_r);
  assign lim_a    = ({4'b0, peer_r} < {13'b0, cong_r[14:8]}) ? {4'b0, peer_r}
                                                             : {13'b0, cong_r[14:8]};
  assign lim_b    = (seg_left < lim_a) ? seg_left : lim_a;

  // Ring accesses per state.
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = mark_slot_r;
    mem_wr_data = {1'b0, tick_r};
    mem_rd_en   = 1'b0;
    mem_rd_addr = mark_slot_r;
    case (state_r)
      S_DECODE: begin
        mem_rd_en   = (cmd_r == CMD_ACK_HDR);
        mem_rd_addr = base_slot_r;
      end
      S_MARK_RD: mem_rd_en = 1'b1;
      S_MARK_WR: begin
        mem_wr_en   = !mem_rd_data[32];
        mem_wr_data = {1'b1, mem_rd_data[31:0]};
      end
      S_DUP_CHK: begin
        mem_wr_en   = !mem_rd_data[32] && can_put;
        mem_wr_addr = base_slot_r;
      end
      S_WALK_RD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = base_slot_r;
      end
      S_FILL: begin
        mem_wr_en   = fill_go && can_put;
        mem_wr_addr = next_slot_r;
      end
      S_TICK_RD: mem_rd_en = 1'b1;
      S_TICK_CHK: mem_wr_en = tick_exp && can_put;
      default: ;
    endcase
  end

  // Sequencer, transfer state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      segcnt_r    <= 20'd1;
      tmo_r       <= 16'd200;
      init_peer_r <= 16'd32;
      cong_r      <= Q_ONE;
      ssl_r       <= Q_START;
      peer_r      <= 16'd32;
      last_ack_r  <= '0;
      dup_r       <= '0;
      rec_r       <= 1'b0;
      rp_r        <= '0;
      base_r      <= '0;
      next_r      <= '0;
      new_ack_r   <= 1'b0;
      taken_r     <= '0;
      tick_r      <= '0;
      base_slot_r <= '0;
      next_slot_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Configuration writes.
      if (cfg_valid) begin
        case (cfg_index)
          REG_SEGMENT_COUNT: segcnt_r    <= cfg_data;
          REG_TIMEOUT:       tmo_r       <= cfg_data[15:0];
          REG_PEER_WINDOW:   init_peer_r <= cfg_data[15:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_tready && !out_load) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r   <= in_tuser[2:0];
            ackf_r  <= in_tuser[3];
            ack_r   <= in_tdata[31:0];
            adv_r   <= in_tdata[47:32];
            sst_r   <= in_tdata[79:48];
            sen_r   <= in_tdata[111:80];
            n_r     <= '0;
            state_r <= S_DECODE;
          end
        end

        S_DECODE: begin
          mark_i_r    <= mark_lo;
          mark_slot_r <= lo_slot;
          case (cmd_r)
            CMD_START: begin
              cong_r      <= Q_ONE;
              ssl_r       <= Q_START;
              peer_r      <= init_peer_r;
              last_ack_r  <= '0;
              dup_r       <= '0;
              rec_r       <= 1'b0;
              rp_r        <= '0;
              base_r      <= '0;
              next_r      <= '0;
              new_ack_r   <= 1'b0;
              taken_r     <= '0;
              base_slot_r <= '0;
              next_slot_r <= '0;
              state_r     <= S_FILL_INIT;
            end
            CMD_ACK_HDR: begin
              if (!ackf_r) begin
                taken_r <= SACK_MAX;
                state_r <= S_STATUS;
              end else begin
                peer_r    <= (adv_r == 16'd0) ? 16'd1 : adv_r;
                taken_r   <= '0;
                mark_hi_r <= hd_hi[19:0];
                mark_ok_r <= ({12'b0, base_r} <= hd_hi);
                if (!ack_ok) begin
                  state_r <= S_STATUS;
                end else if (ack_r > last_ack_r) begin
                  last_ack_r <= ack_r;
                  dup_r      <= '0;
                  state_r    <= S_MARK_START;
                  if (rec_r && (ack_r > {12'b0, rp_r})) begin
                    rec_r  <= 1'b0;
                    cong_r <= (ssl_r > Q_CAP) ? Q_CAP : ssl_r;
                  end
                end else if (ack_r == last_ack_r) begin
                  dup_r <= dup_new;
                  if (!rec_r && (dup_new >= DUP_TRIGGER) && (base_r < segcnt_r)) begin
                    state_r <= (base_r < next_r) ? S_DUP_CHK : S_MARK_START;
                  end else begin
                    state_r <= S_MARK_START;
                    if (rec_r) begin
                      cong_r <= cong_inc_cap;
                    end
                  end
                end else begin
                  dup_r   <= '0;
                  state_r <= S_MARK_START;
                end
              end
            end
            CMD_SACK: begin
              if (taken_r < SACK_MAX) begin
                taken_r   <= 4'(taken_r + 4'd1);
                mark_hi_r <= sk_hi[19:0];
                mark_ok_r <= (sen_r >= st1) && (next_r != 20'd0) && (sk_lo <= sk_hi);
                state_r   <= S_MARK_START;
              end else begin
                state_r <= S_STATUS;
              end
            end
            CMD_ACK_DONE: begin
              if (new_ack_r) begin
                new_ack_r <= 1'b0;
                state_r   <= S_WALK_RD;
              end else begin
                state_r <= S_FILL_INIT;
              end
            end
            CMD_TICK: begin
              // The scan starts at the base slot, set up above.
              tick_r  <= 32'(tick_r + 32'd1);
              state_r <= S_TICK_RD;
            end
            default: state_r <= S_STATUS;
          endcase
        end

        // Fast retransmit of the oldest slot unless it is already acked.
        S_DUP_CHK: begin
          if (mem_rd_data[32]) begin
            state_r <= S_MARK_START;
          end else if (can_put) begin
            ssl_r       <= cut_val;
            cong_r      <= (dup_cong > {1'b0, Q_CAP}) ? Q_CAP : dup_cong[14:0];
            rec_r       <= 1'b1;
            rp_r        <= next_r;
            out_valid_r <= 1'b1;
            out_send_r  <= 1'b1;
            out_seg_r   <= 20'(base_r + 20'd1);
            out_retx_r  <= 1'b1;
            out_last_r  <= 1'b0;
            out_win_r   <= (dup_cong > {1'b0, Q_CAP}) ? Q_CAP : dup_cong[14:0];
            out_old_r   <= base_r;
            out_done_r  <= (base_r >= segcnt_r);
            n_r         <= 6'(n_r + 6'd1);
            state_r     <= S_MARK_START;
          end
        end

        S_MARK_START: state_r <= mark_ok_r ? S_MARK_RD : S_STATUS;

        S_MARK_RD: state_r <= S_MARK_WR;

        S_MARK_WR: begin
          if (!mem_rd_data[32]) begin
            new_ack_r <= 1'b1;
          end
          if (mark_i_r == mark_hi_r) begin
            state_r <= S_STATUS;
          end else begin
            mark_i_r    <= 20'(mark_i_r + 20'd1);
            mark_slot_r <= slot_inc(mark_slot_r);
            state_r     <= S_MARK_RD;
          end
        end

        // Advance the base over acknowledged slots.
        S_WALK_RD: state_r <= (base_r < next_r) ? S_WALK_CHK : S_CWND;

        S_WALK_CHK: begin
          if (mem_rd_data[32]) begin
            base_r      <= 20'(base_r + 20'd1);
            base_slot_r <= slot_inc(base_slot_r);
            state_r     <= S_WALK_RD;
          end else begin
            state_r <= S_CWND;
          end
        end

        S_CWND: begin
          if (cong_r < ssl_r) begin
            cong_r  <= cong_inc_cap;
            state_r <= S_FILL_INIT;
          end else begin
            state_r <= S_DIV;
          end
        end

        S_DIV: begin
          if (div_stat.done) begin
            cong_r  <= (div_sum > {3'b0, Q_CAP}) ? Q_CAP : div_sum[14:0];
            state_r <= S_FILL_INIT;
          end
        end

        // Per-slot timeout scan.
        S_TICK_RD: begin
          state_r <= ((mark_i_r < next_r) && (n_r < MAX_SENDS)) ? S_TICK_CHK
                                                                : S_FILL_INIT;
        end

        S_TICK_CHK: begin
          if (!tick_exp) begin
            mark_i_r    <= 20'(mark_i_r + 20'd1);
            mark_slot_r <= slot_inc(mark_slot_r);
            state_r     <= S_TICK_RD;
          end else if (can_put) begin
            out_valid_r <= 1'b1;
            out_send_r  <= 1'b1;
            out_seg_r   <= 20'(mark_i_r + 20'd1);
            out_retx_r  <= 1'b1;
            out_last_r  <= 1'b0;
            out_win_r   <= cong_r;
            out_old_r   <= base_r;
            out_done_r  <= (base_r >= segcnt_r);
            n_r         <= 6'(n_r + 6'd1);
            ssl_r       <= cut_val;
            cong_r      <= cut_val;
            mark_i_r    <= 20'(mark_i_r + 20'd1);
            mark_slot_r <= slot_inc(mark_slot_r);
            state_r     <= S_TICK_RD;
          end
        end

        // New segments within the window.
        S_FILL_INIT: begin
          limit_r <= lim_b;
          state_r <= (base_r >= segcnt_r) ? S_STATUS : S_FILL;
        end

        S_FILL: begin
          if (!fill_go) begin
            state_r <= S_STATUS;
          end else if (can_put) begin
            next_r      <= 20'(next_r + 20'd1);
            next_slot_r <= slot_inc(next_slot_r);
            out_valid_r <= 1'b1;
            out_send_r  <= 1'b1;
            out_seg_r   <= 20'(next_r + 20'd1);
            out_retx_r  <= 1'b0;
            out_last_r  <= 1'b0;
            out_win_r   <= cong_r;
            out_old_r   <= base_r;
            out_done_r  <= (base_r >= segcnt_r);
            n_r         <= 6'(n_r + 6'd1);
          end
        end

        S_STATUS: begin
          if (can_put) begin
            out_valid_r <= 1'b1;
            out_send_r  <= 1'b0;
            out_seg_r   <= '0;
            out_retx_r  <= 1'b0;
            out_last_r  <= 1'b1;
            out_win_r   <= cong_r;
            out_old_r   <= base_r;
            out_done_r  <= (base_r >= segcnt_r);
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_done_r, out_old_r, out_win_r, out_seg_r};
  assign out_tuser  = {out_retx_r, out_send_r};
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/rsw_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
module rsw_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/rsw_div.sv =====
// Bit-serial restoring divider computing 65536 / divisor, one quotient bit
// per cycle. Depends on rsw_pkg.
`timescale 1ns / 1ps
module rsw_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [14:0]           divisor,
  output rsw_pkg::rsw_div_stat_t stat,
  output logic [16:0]           quotient
);
  import rsw_pkg::*;

  localparam logic [4:0] TOP_BIT = 5'd16;

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [14:0] rem_r;
  logic [16:0] quo_r;
  logic [15:0] trial;
  logic        take;

  // The dividend is 65536: only its top bit is set.
  assign trial = {rem_r, (cnt_r == TOP_BIT)};
  assign take  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= TOP_BIT;
        rem_r  <= '0;
        quo_r  <= '0;
      end else if (busy_r) begin
        if (take) begin
          rem_r <= 15'(trial - {1'b0, divisor});
        end else begin
          rem_r <= trial[14:0];
        end
        quo_r <= {quo_r[15:0], take};
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 5'd1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

// ===== sim/tb_reno_sack_send_window_core.sv =====
// Self-checking testbench for reno_sack_send_window_core: drives command items
// and register writes, and compares every output transfer with a predictor.
// Depends on rsw_pkg and the RTL of the send window engine.
`timescale 1ns / 1ps

// One expected output transfer.
typedef struct {
  bit              send_valid;
  bit [19:0]       send_segment;
  bit              is_retransmit;
  bit              last;
  bit [14:0]       window_now;
  bit [19:0]       oldest_unacked;
  bit              all_done;
} window_result_t;

// Predicts the engine's transfers and checks them in order.
class send_window_scoreboard;
  int unsigned    seg_total, timeout_lim, init_peer;
  int unsigned    cwnd, ss_limit, peer_win, cum_ack, dup_cnt, rec_point;
  int unsigned    base_idx, next_idx, sack_taken, ticks;
  bit             recovering, fresh_ack;
  bit             acked[64];
  int unsigned    sent_at[64];
  int             emitted;
  int             errors;
  window_result_t due_q[$];

  function new();
    seg_total = 1;
    timeout_lim = 200;
    init_peer = 32;
    ticks = 0;
    errors = 0;
    foreach (acked[i]) begin
      acked[i] = 0;
      sent_at[i] = 0;
    end
    restart();
  endfunction

  function void restart();
    cwnd = rsw_pkg::Q_ONE;
    ss_limit = rsw_pkg::Q_START;
    peer_win = init_peer;
    cum_ack = 0;
    dup_cnt = 0;
    recovering = 0;
    rec_point = 0;
    base_idx = 0;
    next_idx = 0;
    fresh_ack = 0;
    sack_taken = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [19:0] val);
    case (idx)
      rsw_pkg::REG_SEGMENT_COUNT: seg_total = val;
      rsw_pkg::REG_TIMEOUT:       timeout_lim = val[15:0];
      rsw_pkg::REG_PEER_WINDOW:   init_peer = val[15:0];
      default: ;
    endcase
  endfunction

  function void emit(bit v, int unsigned seg, bit retx, bit lst);
    window_result_t r;
    r.send_valid = v;
    r.send_segment = seg[19:0];
    r.is_retransmit = retx;
    r.last = lst;
    r.window_now = cwnd[14:0];
    r.oldest_unacked = base_idx[19:0];
    r.all_done = (base_idx >= seg_total);
    due_q = {due_q, r};
    emitted++;
  endfunction

  // Halve the window into the slow-start limit, never below 2.0.
  function void halve();
    ss_limit = ((cwnd >> 1) < rsw_pkg::Q_FLOOR) ? rsw_pkg::Q_FLOOR : (cwnd >> 1);
  endfunction

  function void mark(int unsigned lo, int unsigned hi);
    if (lo < base_idx) lo = base_idx;
    if (next_idx == 0) return;
    if (hi > next_idx - 1) hi = next_idx - 1;
    for (int unsigned i = lo; i <= hi && i < next_idx; i++) begin
      if (!acked[i % 64]) begin
        acked[i % 64] = 1;
        fresh_ack = 1;
      end
    end
  endfunction

  function void fill();
    int unsigned lim;
    if (base_idx >= seg_total) return;
    lim = cwnd >> 8;
    if (peer_win < lim) lim = peer_win;
    if (seg_total - base_idx < lim) lim = seg_total - base_idx;
    while (emitted < rsw_pkg::MAX_SENDS && next_idx < seg_total &&
           next_idx - base_idx < lim) begin
      acked[next_idx % 64] = 0;
      sent_at[next_idx % 64] = ticks;
      next_idx++;
      emit(1, next_idx, 0, 0);
    end
  endfunction

  function void on_header(int unsigned ack, int unsigned adv);
    peer_win = (adv == 0) ? 1 : adv;
    sack_taken = 0;
    if (ack < 1 || ack > next_idx) return;
    if (ack > cum_ack) begin
      cum_ack = ack;
      dup_cnt = 0;
      if (recovering && ack > rec_point) begin
        recovering = 0;
        cwnd = (ss_limit > rsw_pkg::Q_CAP) ? rsw_pkg::Q_CAP : ss_limit;
      end
    end else if (ack == cum_ack) begin
      if (dup_cnt < rsw_pkg::DUP_MAX) dup_cnt++;
      if (!recovering && dup_cnt >= rsw_pkg::DUP_TRIGGER && base_idx < seg_total) begin
        // Fast retransmit of the oldest segment, then fast recovery.
        if (base_idx < next_idx && !acked[base_idx % 64]) begin
          halve();
          cwnd = ss_limit + rsw_pkg::Q_THREE;
          if (cwnd > rsw_pkg::Q_CAP) cwnd = rsw_pkg::Q_CAP;
          recovering = 1;
          rec_point = next_idx & 20'hFFFFF;
          sent_at[base_idx % 64] = ticks;
          emit(1, base_idx + 1, 1, 0);
        end
      end else if (recovering) begin
        cwnd += rsw_pkg::Q_ONE;
        if (cwnd > rsw_pkg::Q_CAP) cwnd = rsw_pkg::Q_CAP;
      end
    end else begin
      dup_cnt = 0;
    end
    mark(0, ack - 1);
  endfunction

  function void on_sack(int unsigned st, int unsigned en);
    if (sack_taken >= 4) return;
    sack_taken++;
    if (st < 1) st = 1;
    if (en < st) return;
    mark(st - 1, en - 1);
  endfunction

  function void on_ack_done();
    if (!fresh_ack) return;
    fresh_ack = 0;
    while (base_idx < next_idx && acked[base_idx % 64]) base_idx++;
    if (cwnd < ss_limit) cwnd += rsw_pkg::Q_ONE;
    else if (cwnd != 0) cwnd += 65536 / cwnd;
    if (cwnd > rsw_pkg::Q_CAP) cwnd = rsw_pkg::Q_CAP;
  endfunction

  function void on_tick();
    ticks++;
    for (int unsigned i = base_idx; i < next_idx && emitted < rsw_pkg::MAX_SENDS; i++) begin
      if (acked[i % 64]) continue;
      if (ticks - sent_at[i % 64] > timeout_lim) begin
        sent_at[i % 64] = ticks;
        emit(1, i + 1, 1, 0);
        halve();
        cwnd = ss_limit;
      end
    end
  endfunction

  // Note an accepted input transfer and queue the transfers it causes.
  function void note_item(logic [2:0] cmd, logic flag, logic [31:0] ack,
                          logic [15:0] adv, logic [31:0] s_lo, logic [31:0] s_hi);
    emitted = 0;
    case (cmd)
      rsw_pkg::CMD_START: begin
        restart();
        fill();
      end
      rsw_pkg::CMD_ACK_HDR: begin
        if (flag) on_header(ack, adv);
        else sack_taken = 4;
      end
      rsw_pkg::CMD_SACK: on_sack(s_lo, s_hi);
      rsw_pkg::CMD_ACK_DONE: begin
        on_ack_done();
        fill();
      end
      rsw_pkg::CMD_TICK: begin
        on_tick();
        fill();
      end
      default: ;
    endcase
    emit(0, 0, 0, 1);
  endfunction

  function void check_result(logic [55:0] data, logic [1:0] user, logic lst);
    window_result_t e;
    if (due_q.size() == 0) begin
      $error("unexpected output transfer: data %h user %b last %b", data, user, lst);
      errors++;
      return;
    end
    e = due_q.pop_front();
    if (user[0] !== e.send_valid) begin
      $error("send_valid: expected %0d, got %0d", e.send_valid, user[0]);
      errors++;
    end
    if (data[19:0] !== e.send_segment) begin
      $error("send_segment: expected %0d, got %0d", e.send_segment, data[19:0]);
      errors++;
    end
    if (user[1] !== e.is_retransmit) begin
      $error("is_retransmit: expected %0d, got %0d", e.is_retransmit, user[1]);
      errors++;
    end
    if (lst !== e.last) begin
      $error("last: expected %0d, got %0d", e.last, lst);
      errors++;
    end
    if (data[34:20] !== e.window_now) begin
      $error("window_now: expected %0d, got %0d", e.window_now, data[34:20]);
      errors++;
    end
    if (data[54:35] !== e.oldest_unacked) begin
      $error("oldest_unacked: expected %0d, got %0d", e.oldest_unacked, data[54:35]);
      errors++;
    end
    if (data[55] !== e.all_done) begin
      $error("all_done: expected %0d, got %0d", e.all_done, data[55]);
      errors++;
    end
  endfunction
endclass

module tb_reno_sack_send_window_core;
  import rsw_pkg::*;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;
  logic [3:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [55:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [19:0]  cfg_data = '0;

  send_window_scoreboard sb = new();
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 0;
  int hold_left = 0;

  reno_sack_send_window_core dut (.*);

  always #4 clk = ~clk;

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready = 1'b0;
    end else begin
      out_tready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Every output transfer is checked at the edge that completes it.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
  end

  task automatic send_item(logic [2:0] cmd, logic flag, logic [31:0] ack,
                           logic [15:0] adv, logic [31:0] s_lo, logic [31:0] s_hi);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {s_hi, s_lo, adv, ack};
    in_tuser = {flag, cmd};
    do @(posedge clk); while (!in_tready);
    sb.note_item(cmd, flag, ack, adv, s_lo, s_hi);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // Registers are written only once every accepted item has finished.
  task automatic write_reg(logic [1:0] idx, logic [19:0] val);
    while (sb.due_q.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Let every expected transfer arrive, then allow for trailing work.
  task automatic drain();
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Mostly well-formed acknowledgement rounds with some noise.
  task automatic random_flow(int count);
    int unsigned a, lo, hi;
    int sel, nblk;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 6) begin
        send_item(CMD_START, 0, 0, 0, 0, 0);
      end else if (sel < 22) begin
        send_item(CMD_TICK, 1'($urandom_range(0, 1)), $urandom, 16'($urandom),
                  $urandom, $urandom);
      end else if (sel < 85) begin
        if (sb.next_idx == 0 || $urandom_range(0, 99) < 40) a = sb.cum_ack;
        else a = $urandom_range(sb.base_idx + 1, sb.next_idx);
        send_item(CMD_ACK_HDR, 1, a, 16'($urandom_range(0, 40)), 0, 0);
        nblk = $urandom_range(0, 5);
        for (int b = 0; b < nblk; b++) begin
          lo = $urandom_range(sb.base_idx, sb.next_idx + 2);
          hi = lo + $urandom_range(0, 6) - 1;
          send_item(CMD_SACK, 0, 0, 0, lo, hi);
        end
        send_item(CMD_ACK_DONE, 0, 0, 0, 0, 0);
      end else begin
        send_item(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), $urandom,
                  16'($urandom), $urandom, $urandom);
      end
    end
  endtask

  // Run-time limit.
  initial begin
    #20ms;
    $display("reno_sack_send_window_core: mismatch");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed items: tick before start, special acks, sack limits, odd commands.
    send_item(CMD_TICK, 0, 0, 0, 0, 0);
    write_reg(REG_SEGMENT_COUNT, 20'd30);
    write_reg(REG_TIMEOUT, 20'd2);
    write_reg(REG_PEER_WINDOW, 20'd65535);
    send_item(CMD_START, 0, 0, 0, 0, 0);
    send_item(CMD_ACK_HDR, 1, 32'd0, 16'd0, 0, 0);
    send_item(CMD_ACK_HDR, 1, 32'hFFFF_FFFF, 16'hFFFF, 0, 0);
    send_item(CMD_ACK_HDR, 1, 32'd1, 16'd8, 0, 0);
    send_item(CMD_ACK_DONE, 0, 0, 0, 0, 0);
    send_item(CMD_ACK_HDR, 0, 32'd3, 16'd8, 0, 0);
    send_item(CMD_SACK, 0, 0, 0, 32'd2, 32'd3);
    send_item(CMD_ACK_HDR, 1, 32'd1, 16'd8, 0, 0);
    for (int b = 0; b < 6; b++) send_item(CMD_SACK, 0, 0, 0, b, b + 1);
    send_item(CMD_SACK, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_ACK_DONE, 0, 0, 0, 0, 0);
    for (int d = 0; d < 3; d++) send_item(CMD_ACK_HDR, 1, 32'd2, 16'd8, 0, 0);
    send_item(CMD_ACK_HDR, 1, 32'd2, 16'd8, 0, 0);
    for (int t = 0; t < 4; t++) send_item(CMD_TICK, 0, 0, 0, 0, 0);
    send_item(3'd7, 1, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(3'd5, 0, 0, 0, 0, 0);
    drain();

    // Phase: long transfer, no idling, then receiver hold-off under load.
    write_reg(REG_SEGMENT_COUNT, 20'd40);
    write_reg(REG_TIMEOUT, 20'd3);
    write_reg(REG_PEER_WINDOW, 20'd32);
    send_item(CMD_START, 0, 0, 0, 0, 0);
    random_flow(10);
    hold_req = 1;
    random_flow(6);
    drain();

    // Phase: smallest settings, sender idling.
    sender_idle_pct = 68;
    write_reg(REG_SEGMENT_COUNT, 20'd1);
    write_reg(REG_TIMEOUT, 20'd1);
    write_reg(REG_PEER_WINDOW, 20'd1);
    send_item(CMD_START, 0, 0, 0, 0, 0);
    random_flow(10);
    drain();

    // Phase: largest settings, receiver stalling.
    sender_idle_pct = 0;
    recv_stall_pct = 68;
    write_reg(REG_SEGMENT_COUNT, 20'hFFFFF);
    write_reg(REG_TIMEOUT, 20'hFFFF);
    write_reg(REG_PEER_WINDOW, 20'hFFFF);
    send_item(CMD_START, 0, 0, 0, 0, 0);
    random_flow(15);
    drain();

    // Phase: shrink the transfer under way, both sides idling a little.
    sender_idle_pct = 11;
    recv_stall_pct = 11;
    write_reg(REG_SEGMENT_COUNT, 20'd5);
    write_reg(REG_TIMEOUT, 20'd2);
    random_flow(9);
    drain();

    // Phase: mid-size transfer with short timeouts, mixed idling.
    write_reg(REG_SEGMENT_COUNT, 20'd100);
    write_reg(REG_PEER_WINDOW, 20'd8);
    send_item(CMD_START, 0, 0, 0, 0, 0);
    random_flow(10);
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    random_flow(10);
    drain();

    if (sb.errors == 0) begin
      $display("reno_sack_send_window_core: match");
    end else begin
      $display("reno_sack_send_window_core: mismatch");
    end
    $finish;
  end
endmodule
